@@ rtl/core/fpg_pkg.sv @@
// ----------------------------------------------------------------------------
// fpg_pkg
// Types, constants and tables shared by the fill pattern generator.
// ----------------------------------------------------------------------------
package fpg_pkg;

	localparam int unsigned ID_W      = 16;
	localparam int unsigned ROW_W     = 16;
	localparam int unsigned ROW_IDX_W = 4;

	localparam logic [ID_W-1:0]      GRAY_LIMIT      = 16'd64;
	localparam logic [ID_W-1:0]      HATCH_START     = 16'h00ff;
	localparam logic [ID_W-1:0]      ROLL_RIGHT_MASK = 16'h8100;
	localparam logic [ID_W-1:0]      ROLL_LEFT_MASK  = 16'h0300;
	localparam logic [ROW_W-1:0]     CHECK_EVEN      = 16'haaaa;
	localparam logic [ROW_W-1:0]     CHECK_ODD       = 16'h5555;
	localparam logic [ROW_IDX_W-1:0] ROW_LAST        = 4'd15;

	// Command queue between the front and back parts (power of two)
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// 8x8 ordered dither threshold matrix
	localparam logic [5:0] BAYER [0:7][0:7] = '{
		'{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
		'{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
		'{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
		'{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
		'{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
		'{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
		'{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
		'{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
	};

	typedef enum logic [1:0] {
		KIND_GRAY,
		KIND_HATCH,
		KIND_CHECK
	} fpg_kind_t;

	// Classified pattern request
	typedef struct packed {
		fpg_kind_t       kind;
		logic            roll_right;
		logic            roll_left;
		logic [ID_W-1:0] id;
	} fpg_cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} fpg_q_stat_t;

endpackage

@@ rtl/core/fpg_if.sv @@
// ----------------------------------------------------------------------------
// fpg_if
// Valid/ready channels of the fill pattern generator.
// ----------------------------------------------------------------------------
interface fpg_id_if;
	logic        valid;
	logic        ready;
	logic [15:0] pattern_id;

	modport source (output valid, output pattern_id, input ready);
	modport sink (input valid, input pattern_id, output ready);
endinterface

interface fpg_row_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row_index;
	logic [15:0] row_bits;
	logic        last_row;

	modport source (output valid, output row_index, output row_bits, output last_row,
		input ready);
	modport sink (input valid, input row_index, input row_bits, input last_row,
		output ready);
endinterface

@@ rtl/core/fpg_front.sv @@
// ----------------------------------------------------------------------------
// fpg_front
// Accept pattern ids and classify them into gray, hatch or checkerboard.
// ----------------------------------------------------------------------------
module fpg_front (
	fpg_id_if.sink             in_ch,
	input  fpg_pkg::fpg_q_stat_t q_stat,
	output logic               push,
	output fpg_pkg::fpg_cmd_t  push_data
);
	import fpg_pkg::*;

	// Take an id whenever the queue has room
	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;

	// Classify the id
	always_comb begin
		push_data.id         = in_ch.pattern_id;
		push_data.roll_right = |(in_ch.pattern_id & ROLL_RIGHT_MASK);
		push_data.roll_left  = |(in_ch.pattern_id & ROLL_LEFT_MASK);
		if (in_ch.pattern_id <= GRAY_LIMIT) begin
			push_data.kind = KIND_GRAY;
		end else if (in_ch.pattern_id >= HATCH_START) begin
			push_data.kind = KIND_HATCH;
		end else begin
			push_data.kind = KIND_CHECK;
		end
	end

endmodule

@@ rtl/core/fpg_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// fpg_cmd_queue
// Short FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module fpg_cmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fpg_pkg::fpg_cmd_t    push_data,
	input  logic                 pop,
	output fpg_pkg::fpg_cmd_t    pop_data,
	output fpg_pkg::fpg_q_stat_t q_stat
);
	import fpg_pkg::*;

	fpg_cmd_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

@@ rtl/core/fpg_back.sv @@
// ----------------------------------------------------------------------------
// fpg_back
// Walk sixteen rows of the current command and drive the row channel.
// ----------------------------------------------------------------------------
module fpg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fpg_pkg::fpg_q_stat_t q_stat,
	input  fpg_pkg::fpg_cmd_t    pop_data,
	output logic                 pop,
	fpg_row_if.source            out_ch
);
	import fpg_pkg::*;

	logic                 busy_q;
	fpg_cmd_t             cmd_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic                 out_valid_q;
	logic [ROW_IDX_W-1:0] out_index_q;
	logic [ROW_W-1:0]     out_bits_q;
	logic                 out_last_q;

	logic                 advance;
	logic                 emit;
	logic                 finish;
	logic [ROW_W-1:0]     row_bits_d;
	logic [2*ROW_W-1:0]   id_pair;
	logic [2*ROW_W-1:0]   rot_r_wide;
	logic [2*ROW_W-1:0]   rot_l_wide;

	// Step when the output register is free or being drained
	assign advance = !out_valid_q || out_ch.ready;
	assign emit    = busy_q && advance;
	assign finish  = emit && (row_q == ROW_LAST);
	assign pop     = !q_stat.empty && (!busy_q || finish);

	// Rotations of the id by the row number
	assign id_pair    = {cmd_q.id, cmd_q.id};
	assign rot_r_wide = id_pair >> row_q;
	assign rot_l_wide = id_pair << row_q;

	// Build the current row
	always_comb begin
		row_bits_d = '0;
		unique case (cmd_q.kind)
			KIND_GRAY: begin
				for (int j = 0; j < 8; j++) begin
					row_bits_d[j]     = cmd_q.id <= {10'd0, BAYER[row_q[2:0]][j]};
					row_bits_d[j + 8] = cmd_q.id <= {10'd0, BAYER[row_q[2:0]][j]};
				end
			end
			KIND_HATCH: begin
				if (cmd_q.roll_right) begin
					row_bits_d = row_bits_d | rot_r_wide[ROW_W-1:0];
				end
				if (cmd_q.roll_left) begin
					row_bits_d = row_bits_d | rot_l_wide[2*ROW_W-1:ROW_W];
				end
			end
			KIND_CHECK: begin
				row_bits_d = row_q[0] ? CHECK_ODD : CHECK_EVEN;
			end
			default: begin
				row_bits_d = '0;
			end
		endcase
	end

	// Sequence rows and load the next command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				row_q <= row_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold command and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_data;
		end
		if (emit) begin
			out_index_q <= row_q;
			out_bits_q  <= row_bits_d;
			out_last_q  <= (row_q == ROW_LAST);
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.row_index = out_index_q;
	assign out_ch.row_bits  = out_bits_q;
	assign out_ch.last_row  = out_last_q;

endmodule

@@ rtl/core/fill_pattern_generator.sv @@
// ----------------------------------------------------------------------------
// fill_pattern_generator
// 16x16 fill stipple from a pattern id: ordered-dither gray, hatch or
// checkerboard, given as sixteen rows.
// ----------------------------------------------------------------------------
//   channel  dir  payload                              one transfer carries
//   in_ch    in   pattern_id[15:0]                     one pattern id
//   out_ch   out  row_index[3:0] row_bits[15:0]        one stipple row
//                 last_row
//
// The back part's row counter emits one row per cycle while out_ch is
// ready. Row 0 leaves after the queue write, the command load and the output
// register. Ids queue up two deep while rows drain, so a new id is taken
// while rows of earlier ones are still going out. Reset clears the queue and
// the output valid; a stalled out_ch holds its row and halts the row counter.
// ----------------------------------------------------------------------------
module fill_pattern_generator (
	input logic      clk,
	input logic      arst_n,
	fpg_id_if.sink   in_ch,
	fpg_row_if.source out_ch
);
	import fpg_pkg::*;

	logic        push;
	logic        pop;
	fpg_cmd_t    push_data;
	fpg_cmd_t    pop_data;
	fpg_q_stat_t q_stat;

	fpg_front u_front (
		.in_ch     (in_ch),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	fpg_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	fpg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.out_ch   (out_ch)
	);

	// Back part never reads an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command popped from empty queue");

	// Front part never overfills the queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("command pushed into full queue");

	// Last-row flag marks exactly the final row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last_row == (out_ch.row_index == ROW_LAST)))
		else $error("last_row does not match row_index");

	// A transfer of a non-final row leaves the next row pending
	a_row_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_row) |=> out_ch.valid)
		else $error("row sequence dropped before last row");

endmodule
